FILE: rtl/scroll_step_accelerator_macros.svh
// assertion macros shared by the checker files
// the clock and reset are taken by name from the module that uses them
`ifndef SCROLL_STEP_ACCELERATOR_MACROS_SVH
`define SCROLL_STEP_ACCELERATOR_MACROS_SVH

// checked on every clock edge outside reset
`define SSA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// checked on every clock edge, reset included
`define SSA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error(msg);

`endif

FILE: rtl/ssa_pkg.sv
package ssa_pkg;

  // queue between the classifier and the executor
  localparam int unsigned QueueDepthDef = 2;

  // configuration port
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CfgMode         = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgSignNegative = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgAccelRate    = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgMaxRate      = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgMaxDelayMs   = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgMinPresses   = 3'd5;

  // mode codes, code 3 behaves like repeat
  localparam logic [1:0] ModeKeyRel = 2'd0;
  localparam logic [1:0] ModeRelRel = 2'd1;
  localparam logic [1:0] ModeRepeat = 2'd2;

  // register reset values
  localparam logic [1:0]         ModeRst       = ModeRelRel;
  localparam logic               SignNegRst    = 1'b0;
  localparam logic signed [15:0] AccelRateRst  = 16'sd256;
  localparam logic [14:0]        MaxRateRst    = 15'd2560;
  localparam logic [15:0]        MaxDelayRst   = 16'd300;
  localparam logic [7:0]         MinPressesRst = 8'd1;

  // rates in signed q16.8
  localparam logic signed [23:0] RateOne = 24'sd256;
  localparam logic signed [24:0] RateMin = -25'sd8388608;
  localparam logic signed [24:0] RateMax = 25'sd8388607;

  typedef enum logic [1:0] {
    CLS_RESET  = 2'd0,
    CLS_REL    = 2'd1,
    CLS_REPEAT = 2'd2
  } cls_e;

  typedef struct packed {
    cls_e              cls;
    logic signed [7:0] value;
  } cmd_t;

  typedef struct packed {
    logic [1:0]         mode;
    logic               sign_negative;
    logic signed [15:0] accel_rate;
    logic [14:0]        max_rate;
    logic [15:0]        max_delay_ms;
    logic [7:0]         min_presses;
  } cfg_t;

endpackage

FILE: rtl/ssa_front.sv
module ssa_front
  import ssa_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [63:0] s_axis_tdata_i,
  output logic        push_o,
  output cmd_t        cmd_o,
  input  logic        full_i
);

  typedef enum logic [3:0] {
    F_IDLE   = 4'b0001,
    F_CALC   = 4'b0010,
    F_CORR   = 4'b0100,
    F_DECIDE = 4'b1000
  } front_state_e;

  localparam logic signed [17:0] MsPerSec = 18'sd1000;

  front_state_e state_q, state_d;

  logic signed [7:0]  v_q;
  logic [31:0]        sec_q, last_sec_q;
  logic [19:0]        usec_q, last_usec_q;
  logic               time_valid_q;
  logic               far_q, far_d, neg_q, neg_d, negu_q, negu_d;
  logic signed [17:0] d1000_q, d1000_d;
  logic [19:0]        mag_q, mag_d;
  logic [10:0]        est_q, est_d;
  logic signed [11:0] uterm_q, uterm_d;

  logic signed [32:0] sd;
  logic signed [7:0]  d8;
  logic signed [20:0] ud, udm;
  logic [30:0]        est_prod;
  logic [20:0]        chk;
  logic [10:0]        q;
  logic signed [18:0] elapsed;
  logic               gt, do_reset, ignore, accept;

  assign s_axis_tready_o = (state_q == F_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  // seconds difference, flagged when far or negative and otherwise cut to 8 bits
  always_comb begin
    sd       = $signed({1'b0, sec_q}) - $signed({1'b0, last_sec_q});
    far_d    = sd > 33'sd66;
    neg_d    = sd < -33'sd1;
    d8       = sd[7:0];
    d1000_d  = $signed({{10{d8[7]}}, d8}) * MsPerSec;
    ud       = $signed({1'b0, usec_q}) - $signed({1'b0, last_usec_q});
    negu_d   = ud[20];
    udm      = negu_d ? -ud : ud;
    mag_d    = udm[19:0];
    // 1049 / 2^20 overestimates 1/1000 by less than half a unit here
    est_prod = 31'(mag_d) * 31'd1049;
    est_d    = est_prod[30:20];
  end

  // fix up the quotient estimate and apply the sign
  always_comb begin
    chk     = 21'(est_q) * 21'd1000;
    q       = (chk > {1'b0, mag_q}) ? (est_q - 11'd1) : est_q;
    uterm_d = negu_q ? -$signed({1'b0, q}) : $signed({1'b0, q});
  end

  always_comb begin
    elapsed  = $signed({d1000_q[17], d1000_q}) + $signed({{7{uterm_q[11]}}, uterm_q});
    gt       = elapsed > $signed({3'b000, cfg_i.max_delay_ms});
    do_reset = !time_valid_q || far_q || (!neg_q && gt);
    ignore   = !do_reset && (cfg_i.mode == ModeKeyRel) && (v_q == 8'sd2);
    cmd_o.value = v_q;
    if (do_reset) begin
      cmd_o.cls = CLS_RESET;
    end else if (cfg_i.mode inside {ModeKeyRel, ModeRelRel}) begin
      cmd_o.cls = CLS_REL;
    end else begin
      cmd_o.cls = CLS_REPEAT;
    end
  end

  always_comb begin
    state_d = state_q;
    push_o  = 1'b0;
    case (state_q)
      F_IDLE: begin
        if (accept && (s_axis_tdata_i[7:0] != 8'd0)) begin
          state_d = F_CALC;
        end
      end
      F_CALC: state_d = F_CORR;
      F_CORR: state_d = F_DECIDE;
      F_DECIDE: begin
        if (ignore) begin
          state_d = F_IDLE;
        end else if (!full_i) begin
          push_o  = 1'b1;
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= F_IDLE;
      time_valid_q <= 1'b0;
      last_sec_q   <= '0;
      last_usec_q  <= '0;
    end else begin
      state_q <= state_d;
      if (push_o) begin
        time_valid_q <= 1'b1;
        last_sec_q   <= sec_q;
        last_usec_q  <= usec_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      v_q    <= s_axis_tdata_i[7:0];
      sec_q  <= s_axis_tdata_i[39:8];
      usec_q <= s_axis_tdata_i[59:40];
    end
    if (state_q == F_CALC) begin
      far_q   <= far_d;
      neg_q   <= neg_d;
      negu_q  <= negu_d;
      d1000_q <= d1000_d;
      mag_q   <= mag_d;
      est_q   <= est_d;
    end
    if (state_q == F_CORR) begin
      uterm_q <= uterm_d;
    end
  end

endmodule

FILE: rtl/ssa_fifo.sv
module ssa_fifo
  import ssa_pkg::*;
#(
  parameter int unsigned Depth = QueueDepthDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t data_i,
  output logic full_o,
  input  logic pop_i,
  output cmd_t data_o,
  output logic empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

FILE: rtl/ssa_back.sv
module ssa_back
  import ssa_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  cmd_t       cmd_i,
  input  logic       cmd_valid_i,
  output logic       cmd_pop_o,
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,
  output logic       m_axis_tlast_o
);

  typedef enum logic [4:0] {
    B_IDLE = 5'b00001,
    B_EXEC = 5'b00010,
    B_SUM  = 5'b00100,
    B_RND  = 5'b01000,
    B_EMIT = 5'b10000
  } back_state_e;

  back_state_e state_q, state_d;

  cmd_t               cmd_q;
  logic signed [23:0] prod_q, prod_d;
  logic [7:0]         press_q, press_d, press_inc;
  logic signed [23:0] rate_q, rate_d;
  logic signed [23:0] ovh_q, ovh_d;
  logic signed [7:0]  em_first_q, em_first_d;
  logic               em_pair_q, em_pair_d;
  logic [1:0]         em_idx_q, em_idx_d;
  logic               out_valid_q, out_valid_d, out_last_q, out_last_d;
  logic signed [7:0]  out_value_q, out_value_d;

  logic signed [7:0]  norm;
  logic signed [24:0] osum, osat, rsum;
  logic signed [23:0] prodn;
  logic [23:0]        mag;
  logic [24:0]        mag_rnd;
  logic [16:0]        rounded;
  logic               neg_res, out_free, em_last;

  assign norm            = cfg_i.sign_negative ? -8'sd1 : 8'sd1;
  assign press_inc       = (press_q == 8'd255) ? press_q : press_q + 8'd1;
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign em_last         = (em_idx_q == 2'd2) || ((em_idx_q == 2'd0) && !em_pair_q);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_value_q;
  assign m_axis_tlast_o  = out_last_q;

  always_comb begin
    prod_d = $signed({{8{cfg_i.accel_rate[15]}}, cfg_i.accel_rate})
           * $signed({{16{cmd_q.value[7]}}, cmd_q.value});
    // repeat mode overhead, saturated to the rate range
    osum = $signed({ovh_q[23], ovh_q}) + $signed({rate_q[23], rate_q});
    if (osum < RateMin) begin
      osat = RateMin;
    end else if (osum > RateMax) begin
      osat = RateMax;
    end else begin
      osat = osum;
    end
    // relative mode rate update
    prodn = cfg_i.sign_negative ? -prod_q : prod_q;
    rsum  = $signed({rate_q[23], rate_q}) + $signed({prodn[23], prodn});
    // rounding half away from zero
    mag     = rate_q[23] ? 24'(-rate_q) : 24'(rate_q);
    mag_rnd = {1'b0, mag} + 25'd128;
    rounded = mag_rnd[24:8];
    neg_res = rate_q[23] ^ cfg_i.sign_negative;
  end

  always_comb begin
    state_d     = state_q;
    cmd_pop_o   = 1'b0;
    press_d     = press_q;
    rate_d      = rate_q;
    ovh_d       = ovh_q;
    em_first_d  = em_first_q;
    em_pair_d   = em_pair_q;
    em_idx_d    = em_idx_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_value_d = out_value_q;
    out_last_d  = out_last_q;
    case (state_q)
      B_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          state_d   = B_EXEC;
        end
      end
      B_EXEC: begin
        em_idx_d = 2'd0;
        case (cmd_q.cls)
          CLS_RESET: begin
            press_d    = 8'd0;
            rate_d     = RateOne;
            ovh_d      = '0;
            em_first_d = norm;
            em_pair_d  = 1'b0;
            state_d    = B_EMIT;
          end
          CLS_REL: begin
            press_d = press_inc;
            state_d = (press_inc >= cfg_i.min_presses) ? B_SUM : B_IDLE;
          end
          default: begin
            em_first_d = norm;
            if (osat > $signed({RateOne[23], RateOne})) begin
              ovh_d     = 24'(osat - $signed({RateOne[23], RateOne}));
              em_pair_d = 1'b1;
            end else begin
              ovh_d     = osat[23:0];
              em_pair_d = 1'b0;
            end
            state_d = B_EMIT;
          end
        endcase
      end
      B_SUM: begin
        // only the upper clamp can bind from above
        if (rsum > $signed({10'd0, cfg_i.max_rate})) begin
          rate_d = 24'($signed({9'd0, cfg_i.max_rate}));
        end else if (rsum < RateMin) begin
          rate_d = RateMin[23:0];
        end else begin
          rate_d = rsum[23:0];
        end
        state_d = B_RND;
      end
      B_RND: begin
        if (neg_res) begin
          em_first_d = (rounded > 17'd128) ? -8'sd128 : -$signed(rounded[7:0]);
        end else begin
          em_first_d = (rounded > 17'd127) ? 8'sd127 : $signed(rounded[7:0]);
        end
        em_pair_d = 1'b0;
        state_d   = B_EMIT;
      end
      B_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_last_d  = em_last;
          case (em_idx_q)
            2'd0:    out_value_d = em_first_q;
            2'd1:    out_value_d = 8'sd0;
            default: out_value_d = norm;
          endcase
          em_idx_d = em_idx_q + 2'd1;
          if (em_last) begin
            state_d = B_IDLE;
          end
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      press_q     <= 8'd0;
      rate_q      <= RateOne;
      ovh_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      press_q     <= press_d;
      rate_q      <= rate_d;
      ovh_q       <= ovh_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      cmd_q <= cmd_i;
    end
    prod_q      <= prod_d;
    em_first_q  <= em_first_d;
    em_pair_q   <= em_pair_d;
    em_idx_q    <= em_idx_d;
    out_value_q <= out_value_d;
    out_last_q  <= out_last_d;
  end

endmodule

FILE: rtl/scroll_step_accelerator.sv
// scroll step accelerator
// input stream: one beat per timestamped step event; a zero step is dropped
// at once and the port stays ready, any other step holds the classifier in
// accept, seconds difference and microsecond quotient estimate, quotient
// fix-up and elapsed-time compare (held while the queue is full) until done
// output stream: 0 to 3 beats per step, tlast on the final beat of a step;
// a dropped step or a step still below the press threshold gives no beat
// the executor handles one queued step at a time: a reset or repeat step
// goes from exec straight to emit, an accelerated relative step multiplies
// in exec, then passes sum and clamp and rounding; emit takes one cycle per
// output beat while the output register is free; a 2-deep command queue lets
// the classifier run ahead
// configuration: write enable, register index and 16-bit data, taken on any
// clock edge with the enable high; write only while the block is idle
// reset clears the step history, press count, rate (1.0) and overhead, and
// loads every register with its default
// a stalled receiver holds the output register, then the executor, then the
// queue, and finally drops tready on the input
module scroll_step_accelerator
  import ssa_pkg::*;
#(
  parameter int unsigned QueueDepth = QueueDepthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration write port
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  // input steps
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // step_value[7:0], time_sec[39:8], time_usec[59:40], zero[63:60]
  input  logic [63:0]         s_axis_tdata_i,
  // output steps
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // out_value[7:0]
  output logic [7:0]          m_axis_tdata_o,
  output logic                m_axis_tlast_o
);

  cfg_t cfg_q;

  // command queue between classifier and executor
  logic push, full, pop, empty;
  cmd_t cmd_in, cmd_out;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode          <= ModeRst;
      cfg_q.sign_negative <= SignNegRst;
      cfg_q.accel_rate    <= AccelRateRst;
      cfg_q.max_rate      <= MaxRateRst;
      cfg_q.max_delay_ms  <= MaxDelayRst;
      cfg_q.min_presses   <= MinPressesRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgMode:         cfg_q.mode          <= cfg_wdata_i[1:0];
        CfgSignNegative: cfg_q.sign_negative <= cfg_wdata_i[0];
        CfgAccelRate:    cfg_q.accel_rate    <= cfg_wdata_i;
        CfgMaxRate:      cfg_q.max_rate      <= cfg_wdata_i[14:0];
        CfgMaxDelayMs:   cfg_q.max_delay_ms  <= cfg_wdata_i;
        CfgMinPresses:   cfg_q.min_presses   <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  // timestamp tracking and step classification
  ssa_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .push_o          (push),
    .cmd_o           (cmd_in),
    .full_i          (full)
  );

  ssa_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (cmd_in),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (cmd_out),
    .empty_o (empty)
  );

  // rate, press count and overhead; result sequencing
  ssa_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .cmd_i           (cmd_out),
    .cmd_valid_i     (!empty),
    .cmd_pop_o       (pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule

FILE: rtl/ssa_checker.sv
`include "scroll_step_accelerator_macros.svh"

module ssa_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic [63:0] s_axis_tdata_i,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [7:0]  m_axis_tdata_o,
  input logic        m_axis_tlast_o
);

  // a stalled output beat holds
  `SSA_ASSERT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o), "output beat changed while stalled")

  // the beats of one step leave back to back
  `SSA_ASSERT(a_frame_contig, m_axis_tvalid_o && m_axis_tready_i && !m_axis_tlast_o |=> m_axis_tvalid_o, "gap inside the beats of one step")

  // a nonzero step keeps the classifier busy
  `SSA_ASSERT(a_busy_after_step, s_axis_tvalid_i && s_axis_tready_o && (s_axis_tdata_i[7:0] != 8'd0) |=> !s_axis_tready_o, "input ready right after a nonzero step")

  // a clock edge in reset leaves the output register empty
  `SSA_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |=> !m_axis_tvalid_o, "output valid after a reset edge")

endmodule

bind scroll_step_accelerator ssa_checker u_ssa_checker (.*);

FILE: dv/scroll_step_accelerator_tb.sv
module scroll_step_accelerator_tb
  import ssa_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // cycles to let the block settle when a step may still be in flight without a beat
  localparam int unsigned SettleCycles = 64;
  // long receiver hold-off used to back the block up into its input
  localparam int unsigned HoldCycles = 400;
  // cycles without any beat on either side before the run is declared hung
  localparam int unsigned QuietLimit = 3000;

  // one expected output beat
  typedef struct packed {
    logic signed [7:0] value;
    logic              last;
  } beat_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx = '0;
  logic [CfgDataW-1:0] cfg_wdata = '0;

  logic        s_valid = 1'b0;
  logic [63:0] s_data = '0;
  logic        s_ready;
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [7:0]  m_data;
  logic        m_last;

  // predictor state, mirrors the block after reset
  cfg_t        cfg_shadow = '{ModeRst, SignNegRst, AccelRateRst, MaxRateRst, MaxDelayRst,
                              MinPressesRst};
  int unsigned presses = 0;
  longint      rate_q8 = 256;
  longint      overhead_q8 = 0;
  logic [31:0] prev_sec = '0;
  logic [19:0] prev_usec = '0;
  bit          stamp_seen = 1'b0;

  beat_t       step_beats[$];

  // event clock of the stimulus in microseconds
  longint      now_us;
  int          burst_left = 0;
  logic        hold_req = 1'b0;
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;

  // receiver pattern state
  int          rx_style = 0;
  int          rx_span = 0;
  int unsigned rx_cyc = 0;

  scroll_step_accelerator i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_ready),
    // step_value[7:0], time_sec[39:8], time_usec[59:40], zero[63:60]
    .s_axis_tdata_i (s_data),
    .m_axis_tvalid_o(m_valid),
    .m_axis_tready_i(m_ready),
    // out_value[7:0]
    .m_axis_tdata_o (m_data),
    .m_axis_tlast_o (m_last)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  function automatic longint clip(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // expected beats of one accepted step, updates the predictor state
  task automatic predict_step(input logic signed [7:0] v, input logic [31:0] sec,
                              input logic [19:0] usec);
    longint                 elapsed;
    longint                 norm;
    longint                 accel;
    longint                 r;
    longint                 mag;
    longint                 rounded;
    longint                 o;
    logic signed [7:0]      outs[$];
    norm  = cfg_shadow.sign_negative ? -1 : 1;
    accel = $signed(cfg_shadow.accel_rate);
    // zero steps vanish without touching anything
    if (v == 0) return;
    elapsed = (longint'(sec) - longint'(prev_sec)) * 1000
            + (longint'(usec) - longint'(prev_usec)) / 1000;
    if (!stamp_seen || elapsed > longint'(cfg_shadow.max_delay_ms)) begin
      // idle too long or first step: start over from 1.0
      presses     = 0;
      rate_q8     = 256;
      overhead_q8 = 0;
      outs.push_back(8'(norm));
    end else if (cfg_shadow.mode == ModeKeyRel || cfg_shadow.mode == ModeRelRel) begin
      // key repeat is dropped in key mode, timestamp kept
      if (cfg_shadow.mode == ModeKeyRel && v == 2) return;
      if (presses < 255) presses++;
      if (presses >= cfg_shadow.min_presses) begin
        r = rate_q8 + accel * longint'(v) * norm;
        if (r > longint'(cfg_shadow.max_rate)) r = longint'(cfg_shadow.max_rate);
        r = clip(r, -64'sd8388608, 64'sd8388607);
        rate_q8 = r;
        // round half away from zero
        mag     = (r < 0) ? -r : r;
        rounded = (mag + 128) / 256;
        if (r < 0) rounded = -rounded;
        outs.push_back(8'(clip(rounded * norm, -128, 127)));
      end
    end else begin
      // repeat mode, code 3 included
      o = clip(overhead_q8 + rate_q8, -64'sd8388608, 64'sd8388607);
      outs.push_back(8'(norm));
      if (o > 256) begin
        outs.push_back(8'sd0);
        outs.push_back(8'(norm));
        o -= 256;
      end
      overhead_q8 = o;
    end
    prev_sec   = sec;
    prev_usec  = usec;
    stamp_seen = 1'b1;
    foreach (outs[i]) step_beats.push_back('{outs[i], i == outs.size() - 1});
  endtask

  // offer one step, bursts of random length with random gaps in between
  task automatic send_step(input logic signed [7:0] v, input logic [31:0] sec,
                           input logic [19:0] usec);
    if (burst_left <= 0) begin
      s_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
      // now and then a long run without gaps
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 8);
    end
    burst_left--;
    s_valid <= 1'b1;
    s_data  <= {4'b0, usec, sec, v};
    do @(posedge clk_i); while (!s_ready);
    predict_step(v, sec, usec);
  endtask

  // step the event clock by delta_us and send one step at the new time
  task automatic step_after(input logic signed [7:0] v, input longint delta_us);
    now_us += delta_us;
    send_step(v, 32'(now_us / 1000000), 20'(now_us % 1000000));
  endtask

  // stop offering, let every expected beat arrive and the block go quiet
  task automatic wait_idle();
    s_valid <= 1'b0;
    burst_left = 0;
    while (step_beats.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] d);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= d;
    @(posedge clk_i);
  endtask

  // full register set, only written with the block idle
  task automatic apply_cfg(input cfg_t c);
    wait_idle();
    write_reg(CfgMode, CfgDataW'(c.mode));
    write_reg(CfgSignNegative, CfgDataW'(c.sign_negative));
    write_reg(CfgAccelRate, c.accel_rate);
    write_reg(CfgMaxRate, CfgDataW'(c.max_rate));
    write_reg(CfgMaxDelayMs, c.max_delay_ms);
    write_reg(CfgMinPresses, CfgDataW'(c.min_presses));
    cfg_we <= 1'b0;
    cfg_shadow = c;
  endtask

  // register defaults: first step, dropped zero, growth, clamp and a negative rate
  task automatic test_reset_defaults();
    step_after(8'sd1, 0);
    step_after(8'sd0, 10_000);
    step_after(8'sd1, 50_000);
    step_after(8'sd127, 20_000);
    step_after(-8'sd128, 20_000);
    step_after(8'sd2, 20_000);
  endtask

  // elapsed time right at the limit, past it, backwards, across the seconds wrap
  task automatic test_time_window();
    step_after(8'sd1, 300_000);
    step_after(8'sd1, 301_000);
    step_after(8'sd1, -5_000_000);
    // seconds field all ones, then wrapping to zero
    now_us = 64'd4294967295 * 1000000 + 999_500;
    step_after(8'sd1, 0);
    step_after(8'sd1, 1000);
    // microseconds beyond the legal range go in as they are
    send_step(8'sd1, 32'(now_us / 1000000), 20'hFFFFF);
    now_us = longint'($urandom()) * 1000000;
  endtask

  // key mode with a negative base step: repeat dropped, presses below the threshold
  task automatic test_key_mode();
    apply_cfg('{ModeKeyRel, 1'b1, 16'sd128, 15'd2560, 16'd300, 8'd3});
    step_after(8'sd1, 10_000_000);
    step_after(8'sd2, 20_000);
    step_after(8'sd1, 20_000);
    // a repeat far in the future starts over, then a step back in time
    step_after(8'sd2, 10_000_000);
    step_after(8'sd1, -10_000_000 + 30_000);
    // another press still below the threshold
    step_after(-8'sd3, 20_000);
  endtask

  // rate hitting the lower bound and the 127 / -128 output saturation
  task automatic test_rate_saturation();
    apply_cfg('{ModeRelRel, 1'b0, -16'sd32768, 15'd32767, 16'd65535, 8'd0});
    step_after(8'sd1, 70_000_000);
    step_after(8'sd127, 1_000);
    step_after(8'sd127, 1_000);
    step_after(8'sd127, 1_000);
    step_after(-8'sd128, 1_000);
    apply_cfg('{ModeRelRel, 1'b0, 16'sd32767, 15'd32767, 16'd65535, 8'd0});
    step_after(8'sd1, 70_000_000);
    step_after(8'sd127, 1_000);
  endtask

  // overhead exactly at 1.0 gives no pair, above it gives a zero and a base step
  task automatic test_repeat_mode();
    apply_cfg('{ModeRepeat, 1'b0, 16'sd256, 15'd2560, 16'd300, 8'd1});
    step_after(8'sd1, 10_000_000);
    step_after(8'sd1, 20_000);
    step_after(8'sd1, 20_000);
    // build a rate of 3.0 in relative mode, then carry it into repeat mode
    apply_cfg('{ModeRelRel, 1'b0, 16'sd512, 15'd2560, 16'd300, 8'd1});
    step_after(8'sd1, 20_000);
    apply_cfg('{2'd3, 1'b1, 16'sd512, 15'd2560, 16'd300, 8'd1});
    step_after(-8'sd5, 20_000);
    step_after(8'sd1, 20_000);
  endtask

  // receiver held off while the sender keeps offering, block must back up
  task automatic test_backpressure();
    apply_cfg('{ModeRepeat, 1'b0, 16'sd256, 15'd2560, 16'd300, 8'd1});
    hold_req   <= 1'b1;
    burst_left = 64;
    for (int i = 0; i < 16; i++) step_after(8'sd1, 10_000);
  endtask

  function automatic cfg_t random_cfg(input int round);
    cfg_t c;
    case (round)
      0: c = '{ModeKeyRel, 1'b0, -16'sd32768, 15'd0, 16'd0, 8'd0};
      1: c = '{2'd3, 1'b1, 16'sd32767, 15'd32767, 16'd65535, 8'd255};
      default: begin
        c.mode          = 2'($urandom_range(0, 3));
        c.sign_negative = 1'($urandom_range(0, 1));
        c.accel_rate    = ($urandom_range(0, 3) == 0) ? 16'($urandom())
                                                      : 16'($urandom_range(0, 768) - 256);
        c.max_rate      = ($urandom_range(0, 3) == 0) ? 15'($urandom())
                                                      : 15'($urandom_range(256, 4096));
        c.max_delay_ms  = ($urandom_range(0, 5) == 0) ? 16'($urandom())
                                                      : 16'($urandom_range(50, 1000));
        c.min_presses   = 8'($urandom_range(0, 4));
      end
    endcase
    return c;
  endfunction

  // mostly well-paced runs of small steps, some gaps past the limit and odd values
  task automatic test_random();
    longint            limit_us;
    longint            delta;
    logic signed [7:0] v;
    int                sent;
    for (int round = 0; round < 6; round++) begin
      apply_cfg(random_cfg(round));
      limit_us = longint'(cfg_shadow.max_delay_ms) * 1000;
      sent = 0;
      while (sent < 45) begin
        case ($urandom_range(0, 15))
          0:       v = 8'sd0;
          1, 2:    v = 8'sd2;
          3, 4, 5, 6, 7, 8, 9: begin
            v = 8'($urandom_range(1, 3));
            if ($urandom_range(0, 1) != 0) v = -v;
          end
          default: v = 8'($urandom());
        endcase
        case ($urandom_range(0, 19))
          16:      delta = limit_us + 1000 + $urandom_range(0, 999);
          17:      delta = limit_us + longint'($urandom_range(2, 5000)) * 1000;
          18:      delta = -longint'($urandom_range(0, 2_000_000));
          19:      delta = 0;
          default: delta = longint'($urandom_range(0, 32'(limit_us) + 999));
        endcase
        step_after(v, delta);
        if (v != 0) sent++;
      end
    end
  endtask

  // receiver: changes its stall pattern after a random span, long hold on request
  initial begin
    forever begin
      @(posedge clk_i);
      rx_cyc++;
      if (hold_req) begin
        hold_req <= 1'b0;
        m_ready  <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end else begin
        if (rx_span <= 0) begin
          rx_style = $urandom_range(0, 3);
          rx_span  = $urandom_range(16, 96);
        end
        rx_span--;
        case (rx_style)
          0:       m_ready <= 1'b1;
          1:       m_ready <= 1'($urandom_range(0, 1));
          2:       m_ready <= (rx_cyc % 4) == 0;
          default: m_ready <= $urandom_range(0, 7) == 0;
        endcase
      end
    end
  end

  // output check against the oldest expected beat
  always @(posedge clk_i) begin
    beat_t want;
    if (rst_ni && m_valid && m_ready) begin
      if (step_beats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected beat: value %0d last %0b", $signed(m_data), m_last);
      end else begin
        want = step_beats.pop_front();
        if (m_data !== want.value || m_last !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("beat mismatch: expected value %0d last %0b, got value %0d last %0b",
                     want.value, want.last, $signed(m_data), m_last);
        end
      end
    end
  end

  // watchdog: too long without any beat on either side
  always @(posedge clk_i) begin
    if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QuietLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    now_us = longint'($urandom()) * 1000000;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_time_window();
    test_key_mode();
    test_rate_saturation();
    test_repeat_mode();
    test_backpressure();
    test_random();
    wait_idle();
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
